// File: hdl/bmhw_pkg.sv
package bmhw_pkg;

	localparam int NUM_BINS  = 64;
	localparam int IDX_W     = $clog2(NUM_BINS);
	localparam int COORD_W   = 16;
	localparam int STEP_W    = 15;
	localparam int BASE_W    = 16;
	localparam int BIN_W     = 16;
	localparam int DIFF_W    = BIN_W + 1;
	localparam int DROP_W    = 16;
	localparam int CFG_W     = 32;
	localparam int ADDR_W    = 3;
	localparam int DIV_CNT_W = $clog2(COORD_W);

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(100);
	localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(-32);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_FLUSH  = 1'b1
	} op_t;

	typedef enum logic {
		REG_STEP = 1'b0,
		REG_BASE = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_WINDOW,
		ST_UPDATE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic                      operation;
		logic signed [COORD_W-1:0] x_mm;
		logic signed [COORD_W-1:0] y_mm;
		logic signed [COORD_W-1:0] z_mm;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] way_x_mm;
		logic signed [COORD_W-1:0] way_y_mm;
		logic signed [COORD_W-1:0] way_z_mm;
		logic signed [BIN_W-1:0]   bin_number;
		logic                      empty_res;
		logic [DROP_W-1:0]         dropped;
		logic                      last;
	} res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} pt_t;

	typedef struct packed {
		logic busy;
		logic div_start;
		logic ram_we;
		logic in_window;
	} ctl_t;

endpackage

// File: hdl/bmhw_ram.sv
module bmhw_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/bmhw_div.sv
module bmhw_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [bmhw_pkg::COORD_W-1:0] dividend,
	input  logic [bmhw_pkg::STEP_W-1:0]         divisor,
	output logic                                done,
	output logic signed [bmhw_pkg::COORD_W-1:0] quotient
);

	logic [bmhw_pkg::COORD_W-1:0]   mag_q;
	logic [bmhw_pkg::STEP_W-1:0]    rem_q;
	logic [bmhw_pkg::STEP_W-1:0]    div_q;
	logic                           neg_q;
	logic [bmhw_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           run_q;
	logic                           done_q;

	logic [bmhw_pkg::STEP_W:0]    shifted;
	logic                         ge;
	logic [bmhw_pkg::STEP_W:0]    diff;
	logic [bmhw_pkg::COORD_W-1:0] abs_in;

	assign abs_in  = dividend[bmhw_pkg::COORD_W-1] ? bmhw_pkg::COORD_W'(-dividend)
	                                                : bmhw_pkg::COORD_W'(dividend);
	assign shifted = {rem_q, mag_q[bmhw_pkg::COORD_W-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bmhw_pkg::DIV_CNT_W'(bmhw_pkg::COORD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= abs_in;
			rem_q <= '0;
			neg_q <= dividend[bmhw_pkg::COORD_W-1];
			div_q <= (divisor == '0) ? bmhw_pkg::STEP_W'(1) : divisor;
		end else if (run_q) begin
			mag_q <= {mag_q[bmhw_pkg::COORD_W-2:0], ge};
			rem_q <= ge ? diff[bmhw_pkg::STEP_W-1:0] : shifted[bmhw_pkg::STEP_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? bmhw_pkg::COORD_W'(-mag_q) : bmhw_pkg::COORD_W'(mag_q);

endmodule

// File: hdl/binned_min_height_waypoints.sv
// Channel   Ports                          Beat taken when
// cmd       start, busy, cmd               start high and busy low
// res       res_stb, res                   res_stb high (one cycle, no back-pressure)
// cfg       psel, penable, pwrite, paddr,  psel, penable, pwrite and pready high
//           pwdata, prdata, pready
//
// An insert holds busy through the bit-per-cycle restoring divide of x by the step, then
// a window check and, unless dropped, a read-modify-write of the bin RAM.
// A flush holds busy for one RAM read per bin and a drain step; an empty flush does not.
// Read data is registered, then loaded into res; busy falls as the last bin read is loaded.
// Reset clears valid bits and drop count and presets step and base; the RAM needs no clear.
// The receiver cannot stall: every strobed beat is taken.
module binned_min_height_waypoints (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bmhw_pkg::cmd_t                cmd,
	output logic                          res_stb,
	output bmhw_pkg::res_t                res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bmhw_pkg::ADDR_W-1:0]   paddr,
	input  logic [bmhw_pkg::CFG_W-1:0]    pwdata,
	output logic [bmhw_pkg::CFG_W-1:0]    prdata,
	output logic                          pready
);

	bmhw_pkg::state_t            state_q, state_d;
	bmhw_pkg::ctl_t              ctl;
	logic [bmhw_pkg::STEP_W-1:0] step_q;
	logic [bmhw_pkg::BASE_W-1:0] base_q;
	logic [bmhw_pkg::DROP_W-1:0] drop_q;
	logic [bmhw_pkg::NUM_BINS-1:0] valid_q;
	bmhw_pkg::pt_t               point_q;
	logic [bmhw_pkg::IDX_W-1:0]  idx_q;
	logic [bmhw_pkg::IDX_W-1:0]  scan_q;
	logic                        hit_s1;
	logic                        last_s1;
	logic [bmhw_pkg::IDX_W-1:0]  idx_s1;
	bmhw_pkg::res_t              res_q;
	logic                        res_stb_q;

	logic                        accept;
	logic                        div_done;
	logic signed [bmhw_pkg::COORD_W-1:0] quot;
	logic signed [bmhw_pkg::DIFF_W-1:0]  diff;
	logic [bmhw_pkg::IDX_W-1:0]  raddr;
	bmhw_pkg::pt_t               rdata;
	logic                        above_any;
	logic                        cfg_we;
	logic [bmhw_pkg::BIN_W-1:0]  bin_sum;

	assign accept = start && !ctl.busy;
	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	bmhw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (cmd.x_mm),
		.divisor  (step_q),
		.done     (div_done),
		.quotient (quot)
	);

	bmhw_ram #(
		.WIDTH ($bits(bmhw_pkg::pt_t)),
		.DEPTH (bmhw_pkg::NUM_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.ram_we),
		.waddr (idx_q),
		.wdata (point_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign diff = bmhw_pkg::DIFF_W'(quot) - bmhw_pkg::DIFF_W'($signed(base_q));

	always_comb begin
		above_any = 1'b0;
		for (int i = 0; i < bmhw_pkg::NUM_BINS; i++) begin
			if (valid_q[i] && (bmhw_pkg::IDX_W'(i) > scan_q)) begin
				above_any = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmhw_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd.operation == bmhw_pkg::OP_INSERT) begin
						state_d = bmhw_pkg::ST_DIV;
					end else if (valid_q != '0) begin
						state_d = bmhw_pkg::ST_SCAN;
					end
				end
			end
			bmhw_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = bmhw_pkg::ST_WINDOW;
				end
			end
			bmhw_pkg::ST_WINDOW: begin
				state_d = ctl.in_window ? bmhw_pkg::ST_UPDATE : bmhw_pkg::ST_IDLE;
			end
			bmhw_pkg::ST_UPDATE: begin
				state_d = bmhw_pkg::ST_IDLE;
			end
			bmhw_pkg::ST_SCAN: begin
				if (scan_q == bmhw_pkg::IDX_W'(bmhw_pkg::NUM_BINS - 1)) begin
					state_d = bmhw_pkg::ST_DRAIN;
				end
			end
			bmhw_pkg::ST_DRAIN: begin
				state_d = bmhw_pkg::ST_IDLE;
			end
			default: begin
				state_d = bmhw_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.busy      = (state_q != bmhw_pkg::ST_IDLE);
		ctl.div_start = (state_q == bmhw_pkg::ST_IDLE) && start
		                && (cmd.operation == bmhw_pkg::OP_INSERT);
		ctl.in_window = !diff[bmhw_pkg::DIFF_W-1]
		                && (diff[bmhw_pkg::DIFF_W-2:0] < (bmhw_pkg::DIFF_W-1)'(bmhw_pkg::NUM_BINS));
		ctl.ram_we    = (state_q == bmhw_pkg::ST_UPDATE)
		                && (!valid_q[idx_q] || (point_q.z < rdata.z));
		raddr         = (state_q == bmhw_pkg::ST_WINDOW) ? diff[bmhw_pkg::IDX_W-1:0] : scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bmhw_pkg::ST_IDLE;
			step_q    <= bmhw_pkg::STEP_RESET;
			base_q    <= bmhw_pkg::BASE_RESET;
			drop_q    <= '0;
			valid_q   <= '0;
			scan_q    <= '0;
			hit_s1    <= 1'b0;
			res_stb_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (paddr[2] == bmhw_pkg::REG_STEP) begin
					step_q <= pwdata[bmhw_pkg::STEP_W-1:0];
				end else begin
					base_q <= pwdata[bmhw_pkg::BASE_W-1:0];
				end
			end
			// count drops, saturating
			if (state_q == bmhw_pkg::ST_WINDOW && !ctl.in_window && drop_q != '1) begin
				drop_q <= drop_q + 1'b1;
			end
			if (ctl.ram_we) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (state_q == bmhw_pkg::ST_DRAIN) begin
				valid_q <= '0;
			end
			if (accept) begin
				scan_q <= '0;
			end else if (state_q == bmhw_pkg::ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
			hit_s1    <= (state_q == bmhw_pkg::ST_SCAN) && valid_q[scan_q];
			res_stb_q <= hit_s1 || (accept && cmd.operation == bmhw_pkg::OP_FLUSH
			                        && valid_q == '0);
		end
	end

	assign bin_sum = base_q + {{(bmhw_pkg::BIN_W - bmhw_pkg::IDX_W){1'b0}}, idx_s1};

	always_ff @(posedge clk) begin
		if (accept) begin
			point_q <= '{x: cmd.x_mm, y: cmd.y_mm, z: cmd.z_mm};
		end
		if (state_q == bmhw_pkg::ST_WINDOW) begin
			idx_q <= diff[bmhw_pkg::IDX_W-1:0];
		end
		idx_s1  <= scan_q;
		last_s1 <= !above_any;
		if (hit_s1) begin
			res_q.way_x_mm   <= rdata.x;
			res_q.way_y_mm   <= rdata.y;
			res_q.way_z_mm   <= rdata.z;
			res_q.bin_number <= bin_sum;
			res_q.empty_res  <= 1'b0;
			res_q.dropped    <= drop_q;
			res_q.last       <= last_s1;
		end else if (accept) begin
			res_q.way_x_mm   <= '0;
			res_q.way_y_mm   <= '0;
			res_q.way_z_mm   <= '0;
			res_q.bin_number <= '0;
			res_q.empty_res  <= 1'b1;
			res_q.dropped    <= drop_q;
			res_q.last       <= 1'b1;
		end
	end

	always_comb begin
		if (paddr[2] == bmhw_pkg::REG_STEP) begin
			prdata = {{(bmhw_pkg::CFG_W - bmhw_pkg::STEP_W){1'b0}}, step_q};
		end else begin
			prdata = {{(bmhw_pkg::CFG_W - bmhw_pkg::BASE_W){base_q[bmhw_pkg::BASE_W-1]}}, base_q};
		end
	end

	assign busy    = ctl.busy;
	assign res_stb = res_stb_q;
	assign res     = res_q;

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && res.empty_res |-> res.last)
		else $error("empty result not marked last");

	a_update_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bmhw_pkg::ST_UPDATE |=> valid_q[$past(idx_q)])
		else $error("bin not valid after update");

	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bmhw_pkg::ST_DRAIN |=> valid_q == '0)
		else $error("table not cleared after flush");

	a_hit_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && !res.empty_res |-> $past(state_q) == bmhw_pkg::ST_SCAN
		                           || $past(state_q) == bmhw_pkg::ST_DRAIN)
		else $error("waypoint beat outside a flush");

	a_drop_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q >= $past(drop_q))
		else $error("drop count went backwards");

endmodule

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		bmhw_pkg::cmd_t beat;
		logic           typed;
		bmhw_pkg::res_t want;
	} dir_row_t;

	localparam int N_DIRECTED = 16;
	localparam int N_PHASES   = 6;
	localparam int SWEEP_PH   = 5;
	localparam int TAIL_WAIT  = 80;

	localparam bmhw_pkg::op_t INS = bmhw_pkg::OP_INSERT;
	localparam bmhw_pkg::op_t FLU = bmhw_pkg::OP_FLUSH;

	// reset window is bins -32..31 at 100 mm
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{'{FLU, 16'sd0,      16'sd0,      16'sd0},      1'b1, '{0, 0, 0, 0, 1, 16'd0, 1}},
		'{'{INS, 16'sd32767,  16'sd0,      16'sd0},      1'b0, '0},
		'{'{INS, -16'sd32768, 16'sd0,      16'sd0},      1'b0, '0},
		'{'{FLU, 16'sd0,      16'sd0,      16'sd0},      1'b1, '{0, 0, 0, 0, 1, 16'd2, 1}},
		'{'{INS, 16'sd0,      16'sd32767,  16'sd32767},  1'b0, '0},
		'{'{INS, 16'sd99,     -16'sd32768, -16'sd32768}, 1'b0, '0},
		'{'{INS, -16'sd99,    16'sd1,      -16'sd32768}, 1'b0, '0},
		'{'{INS, -16'sd3200,  -16'sd1,     16'sd5},      1'b0, '0},
		'{'{INS, 16'sd3199,   16'sd7,      -16'sd7},     1'b0, '0},
		'{'{INS, 16'sd3200,   16'sd0,      16'sd0},      1'b0, '0},
		'{'{INS, -16'sd3300,  16'sd0,      16'sd0},      1'b0, '0},
		'{'{INS, -16'sd3299,  16'sd3,      16'sd4},      1'b0, '0},
		'{'{INS, -16'sd100,   16'sd9,      16'sd0},      1'b0, '0},
		'{'{INS, 16'sd100,    -16'sd9,     16'sd0},      1'b0, '0},
		'{'{FLU, -16'sd1,     -16'sd1,     -16'sd1},     1'b0, '0},
		'{'{FLU, 16'sd0,      16'sd0,      16'sd0},      1'b1, '{0, 0, 0, 0, 1, 16'd4, 1}}
	};

	localparam int PH_STEP [N_PHASES] = '{0, 32767, 1, 5, 0, 100};
	localparam int PH_BASE [N_PHASES] = '{-10, -1, -32768, 32767, 0, -32};
	localparam int PH_IDLE [N_PHASES] = '{0, 59, 0, 13, 59, 13};

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	bmhw_pkg::cmd_t                cmd;
	logic                          res_stb;
	bmhw_pkg::res_t                res;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [bmhw_pkg::ADDR_W-1:0]   paddr;
	logic [bmhw_pkg::CFG_W-1:0]    pwdata;
	logic [bmhw_pkg::CFG_W-1:0]    prdata;
	logic                          pready;

	logic [bmhw_pkg::STEP_W-1:0]   step_r;
	int                            base_r;
	logic                          bin_valid [bmhw_pkg::NUM_BINS];
	bmhw_pkg::pt_t                 bin_pt [bmhw_pkg::NUM_BINS];
	logic [bmhw_pkg::DROP_W-1:0]   drops;
	bmhw_pkg::res_t                waypoints_due [$];
	int                            mismatches;
	int                            idle_pct;

	binned_min_height_waypoints u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.res_stb (res_stb),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("binned_min_height_waypoints test failed");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic fold_beat(input bmhw_pkg::cmd_t c, input logic typed,
	                         input bmhw_pkg::res_t want);
		int             step_e;
		int             bin_i;
		int             idx;
		int             last_i;
		int             i;
		bmhw_pkg::res_t r;
		bmhw_pkg::res_t fresh [$];
		if (c.operation == bmhw_pkg::OP_INSERT) begin
			step_e = (step_r == '0) ? 1 : int'(step_r);
			bin_i  = int'(c.x_mm) / step_e;
			idx    = bin_i - base_r;
			if (idx < 0 || idx >= bmhw_pkg::NUM_BINS) begin
				if (drops != '1)
					drops++;
			end else if (!bin_valid[idx] || c.z_mm < bin_pt[idx].z) begin
				bin_valid[idx] = 1'b1;
				bin_pt[idx]    = '{c.x_mm, c.y_mm, c.z_mm};
			end
		end else begin
			last_i = -1;
			for (i = 0; i < bmhw_pkg::NUM_BINS; i++)
				if (bin_valid[i])
					last_i = i;
			for (i = 0; i < bmhw_pkg::NUM_BINS; i++) begin
				if (bin_valid[i]) begin
					r.way_x_mm   = bin_pt[i].x;
					r.way_y_mm   = bin_pt[i].y;
					r.way_z_mm   = bin_pt[i].z;
					r.bin_number = bmhw_pkg::BIN_W'(base_r + i);
					r.empty_res  = 1'b0;
					r.dropped    = drops;
					r.last       = (i == last_i);
					fresh        = {fresh, r};
					bin_valid[i] = 1'b0;
				end
			end
			if (last_i < 0) begin
				r           = '0;
				r.empty_res = 1'b1;
				r.dropped   = drops;
				r.last      = 1'b1;
				fresh       = {fresh, r};
			end
		end
		if (typed)
			waypoints_due = {waypoints_due, want};
		else
			waypoints_due = {waypoints_due, fresh};
	endtask

	task automatic send_beat(input bmhw_pkg::cmd_t c, input logic typed,
	                         input bmhw_pkg::res_t want);
		int gap;
		gap = (idle_pct > 0 && int'($urandom_range(0, 99)) < idle_pct)
		      ? int'($urandom_range(1, 20)) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		fold_beat(c, typed, want);
	endtask

	task automatic cfg_write(input bmhw_pkg::reg_idx_t ri,
	                         input logic [bmhw_pkg::CFG_W-1:0] v);
		logic [bmhw_pkg::CFG_W-1:0] rd_want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= bmhw_pkg::ADDR_W'(ri) << 2;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (ri == bmhw_pkg::REG_STEP) begin
			step_r  = v[bmhw_pkg::STEP_W-1:0];
			rd_want = bmhw_pkg::CFG_W'(v[bmhw_pkg::STEP_W-1:0]);
		end else begin
			base_r  = int'(signed'(v[bmhw_pkg::BASE_W-1:0]));
			rd_want = bmhw_pkg::CFG_W'(base_r);
		end
		@(posedge clk);
		if (prdata !== rd_want)
			flag_mismatch($sformatf("prdata %h, want %h", prdata, rd_want));
	endtask

	task automatic settle();
		while (waypoints_due.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
	endtask

	always @(posedge clk) begin
		bmhw_pkg::res_t want;
		if (arst_n && res_stb) begin
			if (waypoints_due.size() == 0) begin
				flag_mismatch($sformatf("result beat with none due: %h", res));
			end else begin
				want = waypoints_due.pop_front();
				if (res.way_x_mm !== want.way_x_mm)
					flag_mismatch($sformatf("way_x_mm %0d, want %0d", res.way_x_mm, want.way_x_mm));
				if (res.way_y_mm !== want.way_y_mm)
					flag_mismatch($sformatf("way_y_mm %0d, want %0d", res.way_y_mm, want.way_y_mm));
				if (res.way_z_mm !== want.way_z_mm)
					flag_mismatch($sformatf("way_z_mm %0d, want %0d", res.way_z_mm, want.way_z_mm));
				if (res.bin_number !== want.bin_number)
					flag_mismatch($sformatf("bin_number %0d, want %0d", res.bin_number,
						want.bin_number));
				if (res.empty_res !== want.empty_res)
					flag_mismatch($sformatf("empty_res %b, want %b", res.empty_res, want.empty_res));
				if (res.dropped !== want.dropped)
					flag_mismatch($sformatf("dropped %0d, want %0d", res.dropped, want.dropped));
				if (res.last !== want.last)
					flag_mismatch($sformatf("last %b, want %b", res.last, want.last));
			end
		end
	end

	initial begin
		bmhw_pkg::cmd_t              c;
		logic [bmhw_pkg::CFG_W-1:0]  v;
		int                          step_v;
		int                          base_v;
		int                          n_items;
		int                          step_e;
		int                          idx_pick;
		int                          bin_pick;
		int                          off;
		int                          x_pick;
		logic                        sweep;
		logic                        do_flush;
		start     <= 1'b0;
		cmd       <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		arst_n    <= 1'b0;
		step_r     = bmhw_pkg::STEP_RESET;
		base_r     = int'(signed'(bmhw_pkg::BASE_RESET));
		drops      = '0;
		mismatches = 0;
		idle_pct   = 0;
		foreach (bin_valid[i])
			bin_valid[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
		start <= 1'b0;
		settle();

		for (int p = 0; p < N_PHASES; p++) begin
			step_v = (p == 4) ? int'($urandom_range(1, 400)) : PH_STEP[p];
			base_v = (p == 4) ? int'($urandom_range(0, 300)) - 200 : PH_BASE[p];
			v = $urandom;
			v[bmhw_pkg::STEP_W-1:0] = step_v[bmhw_pkg::STEP_W-1:0];
			cfg_write(bmhw_pkg::REG_STEP, v);
			v = $urandom;
			v[bmhw_pkg::BASE_W-1:0] = base_v[bmhw_pkg::BASE_W-1:0];
			cfg_write(bmhw_pkg::REG_BASE, v);
			idle_pct = PH_IDLE[p];
			sweep    = (p == SWEEP_PH);
			n_items  = sweep ? bmhw_pkg::NUM_BINS + 1 : 60;
			for (int k = 0; k < n_items; k++) begin
				c.y_mm = bmhw_pkg::COORD_W'($urandom);
				if ($urandom_range(0, 1) == 1)
					c.z_mm = bmhw_pkg::COORD_W'($urandom);
				else
					c.z_mm = bmhw_pkg::COORD_W'(int'($urandom_range(0, 7)) - 4);
				c.x_mm = bmhw_pkg::COORD_W'($urandom);
				if (sweep)
					do_flush = (k == n_items - 1);
				else
					do_flush = (k == 30 || k == n_items - 1 || $urandom_range(0, 9) == 0);
				if (do_flush) begin
					c.operation = bmhw_pkg::OP_FLUSH;
				end else begin
					c.operation = bmhw_pkg::OP_INSERT;
					step_e   = (step_r == '0) ? 1 : int'(step_r);
					idx_pick = sweep ? k : int'($urandom_range(0, bmhw_pkg::NUM_BINS + 3)) - 2;
					bin_pick = base_r + idx_pick;
					off      = int'($urandom_range(0, step_e - 1));
					if (bin_pick < 0 || (bin_pick == 0 && $urandom_range(0, 1) == 1))
						x_pick = bin_pick * step_e - off;
					else
						x_pick = bin_pick * step_e + off;
					if ((!sweep && $urandom_range(0, 3) == 0) || x_pick < -32768 || x_pick > 32767)
						x_pick = int'($urandom_range(0, 65535)) - 32768;
					c.x_mm = x_pick[bmhw_pkg::COORD_W-1:0];
				end
				send_beat(c, 1'b0, '0);
				if (k == 30) begin
					start <= 1'b0;
					do @(posedge clk); while (waypoints_due.size() != 0);
				end
			end
			start <= 1'b0;
			settle();
		end

		if (mismatches == 0)
			$display("binned_min_height_waypoints test passed");
		else
			$display("binned_min_height_waypoints test failed");
		$finish;
	end

endmodule
